### hdl/asp_pkg.sv
package asp_pkg;

  localparam int FIELD_W      = 13;
  localparam int MAX_ROWS_DEF = 256;
  localparam int CFG_IDX_W    = 1;

  // register reset values
  localparam logic [FIELD_W-1:0] ATLAS_WIDTH_RST  = FIELD_W'(512);
  localparam logic [FIELD_W-1:0] ATLAS_HEIGHT_RST = FIELD_W'(512);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'b1;

  // command codes
  localparam logic CMD_PLACE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // one row of the shelf table
  typedef struct packed {
    logic [FIELD_W-1:0] used;
    logic [FIELD_W-1:0] top;
    logic [FIELD_W-1:0] height;
  } row_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

### hdl/asp_ram.sv
module asp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/atlas_shelf_packer.sv
// channel   | beat marked by    | payload
// ----------+-------------------+----------------------------------------
// request   | start && !busy    | command, glyph_width, glyph_height
// result    | done (one cycle)  | placed, place_x, place_y
// config    | cfg_we            | cfg_index, cfg_data (atlas width/height)
//
// a place request keeps busy high while it issues a row read per open row on the
// single ram read port, waits for the last read to land and then decides and writes
// back; done follows in the next cycle, when the next request may already be taken
// a clear answers in the next cycle without raising busy; rst is synchronous,
// empties the row table and restores register defaults; done cannot be stalled
module atlas_shelf_packer #(
  parameter int MAX_ROWS = asp_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request
  input  logic                           start,
  output logic                           busy,
  input  logic                           command,
  input  logic [asp_pkg::FIELD_W-1:0]    glyph_width,
  input  logic [asp_pkg::FIELD_W-1:0]    glyph_height,
  // result
  output logic                           done,
  output logic                           placed,
  output logic [asp_pkg::FIELD_W-1:0]    place_x,
  output logic [asp_pkg::FIELD_W-1:0]    place_y,
  // configuration
  input  logic                           cfg_we,
  input  logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asp_pkg::FIELD_W-1:0]    cfg_data
);

  localparam int W     = asp_pkg::FIELD_W;
  localparam int IDX_W = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  // configuration registers
  logic [W-1:0] sheet_width;
  logic [W-1:0] sheet_height;

  // control state
  asp_pkg::state_t state, state_next;
  logic [CNT_W-1:0] rows_open, rows_open_next;
  logic [CNT_W-1:0] issue_cnt, issue_cnt_next;
  logic             pend, pend_next;          // ram read data valid this cycle
  logic [IDX_W-1:0] pend_idx, pend_idx_next;  // row that read data belongs to
  logic [W-1:0]     next_top, next_top_next;  // bottom edge of the last row

  // request held during the scan
  logic [W-1:0] gw, gw_next;
  logic [W-1:0] gh, gh_next;

  // best row so far
  logic             found, found_next;
  logic [W-1:0]     best_h, best_h_next;
  logic [IDX_W-1:0] best_idx, best_idx_next;
  logic [W-1:0]     best_used, best_used_next;
  logic [W-1:0]     best_top, best_top_next;

  // result registers
  logic         done_next;
  logic         placed_next;
  logic [W-1:0] place_x_next;
  logic [W-1:0] place_y_next;

  // row ram access
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  asp_pkg::row_t    ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  asp_pkg::row_t    ram_rdata;

  // scan compare terms
  logic [W:0] used_sum;
  logic       row_fits;
  logic [W:0] new_bottom;
  logic       scan_end;

  asp_ram #(
    .WIDTH ($bits(asp_pkg::row_t)),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state == asp_pkg::ST_SCAN);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_width  <= asp_pkg::ATLAS_WIDTH_RST;
      sheet_height <= asp_pkg::ATLAS_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        asp_pkg::REG_ATLAS_WIDTH:  sheet_width  <= cfg_data;
        asp_pkg::REG_ATLAS_HEIGHT: sheet_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= asp_pkg::ST_IDLE;
      rows_open <= '0;
      next_top  <= '0;
      pend      <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      rows_open <= rows_open_next;
      next_top  <= next_top_next;
      pend      <= pend_next;
      done      <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    issue_cnt <= issue_cnt_next;
    pend_idx  <= pend_idx_next;
    gw        <= gw_next;
    gh        <= gh_next;
    found     <= found_next;
    best_h    <= best_h_next;
    best_idx  <= best_idx_next;
    best_used <= best_used_next;
    best_top  <= best_top_next;
    placed    <= placed_next;
    place_x   <= place_x_next;
    place_y   <= place_y_next;
  end

  // row test on the data coming back from the ram, sums one bit wider
  assign used_sum   = {1'b0, ram_rdata.used} + {1'b0, gw};
  assign row_fits   = pend && (used_sum <= {1'b0, sheet_width})
                      && (ram_rdata.height >= gh) && (ram_rdata.height < best_h);
  assign new_bottom = {1'b0, next_top} + {1'b0, gh};
  assign scan_end   = (issue_cnt == rows_open) && !pend;

  always_comb begin
    state_next     = state;
    rows_open_next = rows_open;
    next_top_next  = next_top;
    issue_cnt_next = issue_cnt;
    pend_next      = 1'b0;
    pend_idx_next  = pend_idx;
    gw_next        = gw;
    gh_next        = gh;
    found_next     = found;
    best_h_next    = best_h;
    best_idx_next  = best_idx;
    best_used_next = best_used;
    best_top_next  = best_top;
    done_next      = 1'b0;
    placed_next    = placed;
    place_x_next   = place_x;
    place_y_next   = place_y;
    ram_we         = 1'b0;
    ram_waddr      = best_idx;
    ram_wdata      = '0;
    ram_raddr      = issue_cnt[IDX_W-1:0];

    unique case (state)
      asp_pkg::ST_IDLE: begin
        if (start) begin
          if (command == asp_pkg::CMD_CLEAR) begin
            rows_open_next = '0;
            next_top_next  = '0;
            done_next      = 1'b1;
            placed_next    = 1'b1;
            place_x_next   = '0;
            place_y_next   = '0;
          end else begin
            state_next     = asp_pkg::ST_SCAN;
            issue_cnt_next = '0;
            gw_next        = glyph_width;
            gh_next        = glyph_height;
            found_next     = 1'b0;
            best_h_next    = sheet_height;
          end
        end
      end

      asp_pkg::ST_SCAN: begin
        // issue one read per open row
        if (issue_cnt < rows_open) begin
          pend_next      = 1'b1;
          pend_idx_next  = issue_cnt[IDX_W-1:0];
          issue_cnt_next = issue_cnt + CNT_W'(1);
        end
        // a fitting row wins only if strictly lower than the best so far; on a tie the first stays
        if (row_fits) begin
          found_next     = 1'b1;
          best_h_next    = ram_rdata.height;
          best_idx_next  = pend_idx;
          best_used_next = ram_rdata.used;
          best_top_next  = ram_rdata.top;
        end
        if (scan_end) begin
          state_next = asp_pkg::ST_IDLE;
          done_next  = 1'b1;
          if (found) begin
            ram_we           = 1'b1;
            ram_waddr        = best_idx;
            ram_wdata.used   = best_used + gw;
            ram_wdata.top    = best_top;
            ram_wdata.height = best_h;
            placed_next      = 1'b1;
            place_x_next     = best_used;
            place_y_next     = best_top;
          end else if ((rows_open < CNT_W'(MAX_ROWS))
                       && (new_bottom <= {1'b0, sheet_height})) begin
            // open a new shelf below the last one
            ram_we           = 1'b1;
            ram_waddr        = rows_open[IDX_W-1:0];
            ram_wdata.used   = gw;
            ram_wdata.top    = next_top;
            ram_wdata.height = gh;
            rows_open_next   = rows_open + CNT_W'(1);
            next_top_next    = new_bottom[W-1:0];
            placed_next      = 1'b1;
            place_x_next     = '0;
            place_y_next     = next_top;
          end else begin
            placed_next  = 1'b0;
            place_x_next = '0;
            place_y_next = '0;
          end
        end
      end

      default: begin
        state_next = asp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/asp_checker.sv
module asp_props (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          command,
  input logic [asp_pkg::FIELD_W-1:0]   glyph_width,
  input logic [asp_pkg::FIELD_W-1:0]   glyph_height,
  input logic                          done,
  input logic                          placed,
  input logic [asp_pkg::FIELD_W-1:0]   place_x,
  input logic [asp_pkg::FIELD_W-1:0]   place_y,
  input logic                          cfg_we,
  input logic [asp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [asp_pkg::FIELD_W-1:0]   cfg_data
);

  // an accepted beat either starts a scan or answers at once
  a_accept_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither scanned nor answered");

  // end of a scan always delivers its result beat
  a_scan_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe during a scan");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !placed) |-> (place_x == '0 && place_y == '0))
    else $error("failed placement with nonzero position");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == asp_pkg::CMD_CLEAR)
      |=> (done && placed && place_x == '0 && place_y == '0))
    else $error("clear did not answer placed at origin");

endmodule

bind atlas_shelf_packer asp_props u_asp_props (.*);

### dv/asp_checker.sv
`timescale 1ns / 100ps

module asp_checker
  import asp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               command,
  input  logic [FIELD_W-1:0] glyph_width,
  input  logic [FIELD_W-1:0] glyph_height,
  input  logic               done,
  input  logic               placed,
  input  logic [FIELD_W-1:0] place_x,
  input  logic [FIELD_W-1:0] place_y,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 beats_seen,
  output int                 refused_seen,
  output int                 peak_shelves
);

  typedef struct packed {
    logic               placed;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } spot_t;

  // shadow of the shelf table and the atlas size
  logic [FIELD_W-1:0] shelf_used   [MAX_ROWS_DEF];
  logic [FIELD_W-1:0] shelf_top    [MAX_ROWS_DEF];
  logic [FIELD_W-1:0] shelf_height [MAX_ROWS_DEF];
  int                 shelves_open;
  logic [FIELD_W-1:0] atlas_w;
  logic [FIELD_W-1:0] atlas_h;

  spot_t spots_due[$];

  // best-height fit over open shelves, else open a new shelf below the last; a clear empties them
  function automatic spot_t pack_glyph(logic cmd, logic [FIELD_W-1:0] gw,
                                       logic [FIELD_W-1:0] gh);
    spot_t spot;
    int    best_h;
    int    best_i;
    int    new_top;
    int    i;
    bit    found;
    spot    = '0;
    best_h  = int'(atlas_h);
    best_i  = 0;
    found   = 1'b0;
    new_top = 0;
    if (cmd == CMD_CLEAR) begin
      shelves_open = 0;
      spot.placed  = 1'b1;
      return spot;
    end
    for (i = 0; i < shelves_open; i++) begin
      if (int'(shelf_used[i]) + int'(gw) <= int'(atlas_w) &&
          shelf_height[i] >= gh && int'(shelf_height[i]) < best_h) begin
        best_h = int'(shelf_height[i]);
        best_i = i;
        found  = 1'b1;
      end
    end
    if (found) begin
      spot.placed          = 1'b1;
      spot.x               = shelf_used[best_i];
      spot.y               = shelf_top[best_i];
      shelf_used[best_i]   = shelf_used[best_i] + gw;
    end else if (shelves_open < MAX_ROWS_DEF) begin
      if (shelves_open > 0)
        new_top = int'(shelf_top[shelves_open-1]) + int'(shelf_height[shelves_open-1]);
      if (new_top + int'(gh) <= int'(atlas_h)) begin
        shelf_used[shelves_open]   = gw;
        shelf_top[shelves_open]    = new_top[FIELD_W-1:0];
        shelf_height[shelves_open] = gh;
        shelves_open++;
        spot.placed = 1'b1;
        spot.y      = new_top[FIELD_W-1:0];
      end
    end
    return spot;
  endfunction

  always @(posedge clk) begin
    spot_t want;
    if (rst) begin
      shelves_open = 0;
      atlas_w      = ATLAS_WIDTH_RST;
      atlas_h      = ATLAS_HEIGHT_RST;
      spots_due.delete();
      fail_count   <= 0;
      beats_seen   <= 0;
      refused_seen <= 0;
      peak_shelves <= 0;
    end else begin
      // result beat first: it always belongs to an earlier request
      if (done) begin
        beats_seen <= beats_seen + 1;
        if (!placed)
          refused_seen <= refused_seen + 1;
        if (spots_due.size() == 0) begin
          $display("%0t: result beat with nothing expected (placed %0d x %0d y %0d)",
                   $time, placed, place_x, place_y);
          fail_count <= fail_count + 1;
        end else begin
          want = spots_due.pop_front();
          if (placed !== want.placed || place_x !== want.x || place_y !== want.y) begin
            if (placed !== want.placed)
              $display("%0t: placed expected %0d actual %0d", $time, want.placed, placed);
            if (place_x !== want.x)
              $display("%0t: place_x expected %0d actual %0d", $time, want.x, place_x);
            if (place_y !== want.y)
              $display("%0t: place_y expected %0d actual %0d", $time, want.y, place_y);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_ATLAS_WIDTH)
          atlas_w = cfg_data;
        else if (cfg_index == REG_ATLAS_HEIGHT)
          atlas_h = cfg_data;
      end
      if (start && !busy) begin
        spots_due.push_back(pack_glyph(command, glyph_width, glyph_height));
        if (shelves_open > peak_shelves)
          peak_shelves <= shelves_open;
      end
    end
    pending <= spots_due.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import asp_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               command;
  logic [FIELD_W-1:0] glyph_width;
  logic [FIELD_W-1:0] glyph_height;
  logic               done;
  logic               placed;
  logic [FIELD_W-1:0] place_x;
  logic [FIELD_W-1:0] place_y;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int beats_seen;
  int refused_seen;
  int peak_shelves;

  // atlas size currently programmed, used to scale random glyphs
  int  atlas_w;
  int  atlas_h;
  // when set the sender never idles between beats
  bit  steady;

  atlas_shelf_packer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .done         (done),
    .placed       (placed),
    .place_x      (place_x),
    .place_y      (place_y),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  asp_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .done         (done),
    .placed       (placed),
    .place_x      (place_x),
    .place_y      (place_y),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .beats_seen   (beats_seen),
    .refused_seen (refused_seen),
    .peak_shelves (peak_shelves)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // hard stop well past the slowest legal run (every scan at full depth)
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one request beat: optional idle gap, then hold start until !busy at an edge
  task automatic send_beat(input logic cmd, input int w, input int h);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    command      <= cmd;
    glyph_width  <= w[FIELD_W-1:0];
    glyph_height <= h[FIELD_W-1:0];
    do @(posedge clk); while (busy);
  endtask

  // drop start and wait for every outstanding result, plus a small margin
  // since pending is a registered copy of the checker's queue size
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_atlas(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ATLAS_WIDTH;
    cfg_data  <= w[FIELD_W-1:0];
    @(posedge clk);
    cfg_index <= REG_ATLAS_HEIGHT;
    cfg_data  <= h[FIELD_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    atlas_w = w;
    atlas_h = h;
  endtask

  // mostly well-sized glyphs from a few shelf heights so rows get reused,
  // plus clears and oversize noise
  task automatic random_glyph(input int h0, input int h1, input int h2);
    int sel;
    int w;
    int h;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      send_beat(CMD_CLEAR, $urandom_range(0, 4096), $urandom_range(0, 4096));
    end else if (sel < 12) begin
      send_beat(CMD_PLACE, $urandom_range(0, 4096), $urandom_range(0, 4096));
    end else begin
      w = $urandom_range(0, atlas_w / 4 + 1);
      case ($urandom_range(0, 3))
        0: h = h0;
        1: h = h1;
        2: h = h2;
        default: h = $urandom_range(0, atlas_h / 6 + 1);
      endcase
      send_beat(CMD_PLACE, w, h);
    end
  endtask

  initial begin
    int p;
    int n;
    int h0;
    int h1;
    int h2;
    rst          <= 1'b1;
    start        <= 1'b0;
    command      <= CMD_PLACE;
    glyph_width  <= '0;
    glyph_height <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_ATLAS_WIDTH;
    cfg_data     <= '0;
    steady       = 1'b0;
    atlas_w      = 512;
    atlas_h      = 512;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default 512 x 512 atlas
    send_beat(CMD_PLACE, 10, 20);      // first shelf at the top
    send_beat(CMD_PLACE, 10, 20);      // same shelf, x advances
    send_beat(CMD_PLACE, 10, 10);      // shorter glyph reuses it
    send_beat(CMD_PLACE, 600, 30);     // new shelf wider than the atlas
    send_beat(CMD_PLACE, 5, 5);        // best fit back on the first shelf
    send_beat(CMD_PLACE, 0, 0);        // empty glyph
    send_beat(CMD_PLACE, 100, 500);    // no space left in height
    send_beat(CMD_PLACE, 4096, 462);   // fills the atlas to the bottom edge
    send_beat(CMD_PLACE, 1, 4096);     // refused
    send_beat(CMD_CLEAR, 4095, 4095);
    send_beat(CMD_PLACE, 512, 512);    // shelf of full atlas height
    send_beat(CMD_PLACE, 1, 1);        // that shelf is never reused
    send_beat(CMD_CLEAR, 0, 0);
    drain();

    // largest atlas
    write_atlas(4096, 4096);
    send_beat(CMD_PLACE, 4096, 4096);
    send_beat(CMD_PLACE, 0, 0);        // zero-height shelf at the very bottom
    send_beat(CMD_PLACE, 0, 0);        // and it gets reused
    send_beat(CMD_CLEAR, 0, 0);
    drain();

    // smallest atlas
    write_atlas(1, 1);
    send_beat(CMD_PLACE, 1, 1);
    send_beat(CMD_PLACE, 1, 1);
    send_beat(CMD_PLACE, 0, 0);
    send_beat(CMD_CLEAR, 0, 0);
    drain();

    // one-pixel-wide atlas, tall: nearly every glyph opens a shelf until the
    // table runs out of slots, no idling for this stretch
    write_atlas(1, 4096);
    steady = 1'b1;
    for (n = 0; n < 300; n++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(CMD_PLACE, 0, $urandom_range(0, 12));
      else
        send_beat(CMD_PLACE, 1, $urandom_range(0, 12));
    end
    steady = 1'b0;
    drain();

    // random phases; the size changes without a clear so old shelves carry over
    for (p = 0; p < 10; p++) begin
      case (p % 5)
        0: write_atlas(4096, 4096);
        1: write_atlas(1, 1);
        2: write_atlas(512, 512);
        default: write_atlas($urandom_range(1, 4096), $urandom_range(1, 4096));
      endcase
      h0 = $urandom_range(0, atlas_h / 8 + 1);
      h1 = $urandom_range(0, atlas_h / 8 + 1);
      h2 = $urandom_range(0, atlas_h / 4 + 1);
      steady = (p % 3 == 2);
      for (n = 0; n < 60; n++) begin
        // hold off mid-phase until the result stream has caught up
        if (n == 30)
          drain();
        random_glyph(h0, h1, h2);
      end
      steady = 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    $display("ran %0d request beats, %0d refused for lack of space", beats_seen,
             refused_seen);
    $display("shelf table reached %0d open shelves; atlas sizes from 1 to 4096",
             peak_shelves);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
